[design/page_free_list_allocator_macros.svh]
// ---------------------------------------------------------------------------
// Page free list allocator - assertion macros
// Shorthand for clocked checks, all disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef PAGE_FREE_LIST_ALLOCATOR_MACROS_SVH
`define PAGE_FREE_LIST_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define PFLA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFLA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pfla_pkg.sv]
// ---------------------------------------------------------------------------
// Page free list allocator - package
// Sizes, codes and the controller/datapath interface types.
// ---------------------------------------------------------------------------
`default_nettype none

package pfla_pkg;

    localparam int unsigned PAGE_COUNT     = 128;
    localparam int unsigned PAGES_PER_PROC = 4;

    localparam int unsigned ADDR_W = $clog2(PAGE_COUNT);       // page address
    localparam int unsigned LINK_W = $clog2(PAGE_COUNT + 1);   // link, incl. null
    localparam int unsigned CNT_W  = $clog2(PAGE_COUNT + 1);   // free count
    localparam int unsigned WALK_W = $clog2(PAGE_COUNT + 1);   // walk step count
    localparam int unsigned BUF_W  = (PAGES_PER_PROC > 1) ? $clog2(PAGES_PER_PROC) : 1;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(PAGE_COUNT);

    typedef enum logic {
        REQ_ALLOC   = 1'b0,
        REQ_RELEASE = 1'b1
    } req_type_t;

    typedef enum logic {
        ST_DONE    = 1'b0,
        ST_REFUSED = 1'b1
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_A_WALK,
        S_A_EMIT,
        S_R_WALK,
        S_ACK,
        S_REFUSE
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic alloc_start;
        logic alloc_step;
        logic alloc_commit;
        logic rel_start;
        logic rel_step;
        logic rel_commit;
        logic out_page;
        logic out_ack;
        logic out_refuse;
    } pfla_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic free_low;
        logic head_ok;
        logic chain_ok;
        logic link_ok;
        logic walk_done;
        logic walk_limit;
        logic emit_last;
    } pfla_stat_t;

endpackage

`default_nettype wire

[design/pfla_ram.sv]
// ---------------------------------------------------------------------------
// Page free list allocator - generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module pfla_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/pfla_datapath.sv]
// ---------------------------------------------------------------------------
// Page free list allocator - datapath
// Link memory, free head and count, walk counter, page buffer, result regs.
// ---------------------------------------------------------------------------
`default_nettype none

module pfla_datapath
    import pfla_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [ADDR_W-1:0] chain_head,
    input  wire pfla_cmd_t         cmd,
    output pfla_stat_t             stat,
    output logic                   done,
    output logic                   status,
    output logic      [ADDR_W-1:0] page_addr,
    output logic      [CNT_W-1:0]  free_count,
    output logic                   last
);

    logic [ADDR_W-1:0] clr_idx_reg;
    logic [LINK_W-1:0] free_head_reg;
    logic [CNT_W-1:0]  free_count_reg;
    logic [WALK_W-1:0] walk_cnt_reg;
    logic [ADDR_W-1:0] prev_reg;
    logic [ADDR_W-1:0] rel_head_reg;
    logic [BUF_W-1:0]  emit_idx_reg;
    logic [ADDR_W-1:0] page_buf_reg [PAGES_PER_PROC];

    logic              done_reg;
    logic              status_reg;
    logic [ADDR_W-1:0] page_addr_reg;
    logic [CNT_W-1:0]  free_count_out_reg;
    logic              last_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [LINK_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [LINK_W-1:0] ram_rdata;
    logic [CNT_W:0]    count_sum;
    logic [CNT_W-1:0]  count_sat;

    pfla_ram #(
        .WIDTH (LINK_W),
        .DEPTH (PAGE_COUNT)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // read data is always the link of the page addressed in the previous cycle
    always_comb
    begin
        ram_raddr = ram_rdata[ADDR_W-1:0];
        if (cmd.alloc_start)
        begin
            ram_raddr = free_head_reg[ADDR_W-1:0];
        end
        else if (cmd.rel_start)
        begin
            ram_raddr = chain_head;
        end

        ram_we    = 1'b0;
        ram_waddr = clr_idx_reg;
        ram_wdata = LINK_W'(clr_idx_reg) + LINK_W'(1);
        if (cmd.clr_step)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.alloc_commit)
        begin
            ram_we    = 1'b1;
            ram_waddr = page_buf_reg[PAGES_PER_PROC-1];
            ram_wdata = NULL_LINK;
        end
        else if (cmd.rel_commit)
        begin
            ram_we    = 1'b1;
            ram_waddr = prev_reg;
            ram_wdata = free_head_reg;
        end

        count_sum = {1'b0, free_count_reg} + (CNT_W+1)'(PAGES_PER_PROC);
        count_sat = (count_sum > (CNT_W+1)'(PAGE_COUNT)) ? CNT_W'(PAGE_COUNT)
                                                          : count_sum[CNT_W-1:0];
    end

    always_comb
    begin
        stat.clr_last   = (clr_idx_reg == ADDR_W'(PAGE_COUNT - 1));
        stat.free_low   = (free_count_reg < CNT_W'(PAGES_PER_PROC));
        stat.head_ok    = (free_head_reg < NULL_LINK);
        stat.chain_ok   = (LINK_W'(chain_head) < NULL_LINK);
        stat.link_ok    = (ram_rdata < NULL_LINK);
        stat.walk_done  = (walk_cnt_reg == WALK_W'(PAGES_PER_PROC));
        stat.walk_limit = (walk_cnt_reg == WALK_W'(PAGE_COUNT));
        stat.emit_last  = (emit_idx_reg == BUF_W'(PAGES_PER_PROC - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg    <= '0;
            free_head_reg  <= '0;
            free_count_reg <= CNT_W'(PAGE_COUNT);
            walk_cnt_reg   <= '0;
            emit_idx_reg   <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_idx_reg <= clr_idx_reg + ADDR_W'(1);
            end
            if (cmd.alloc_start || cmd.rel_start)
            begin
                walk_cnt_reg <= WALK_W'(1);
            end
            else if (cmd.alloc_step || cmd.rel_step)
            begin
                walk_cnt_reg <= walk_cnt_reg + WALK_W'(1);
            end
            if (cmd.alloc_commit)
            begin
                free_head_reg  <= ram_rdata;
                free_count_reg <= free_count_reg - CNT_W'(PAGES_PER_PROC);
                emit_idx_reg   <= '0;
            end
            else if (cmd.rel_commit)
            begin
                free_head_reg  <= LINK_W'(rel_head_reg);
                free_count_reg <= count_sat;
            end
            if (cmd.out_page)
            begin
                emit_idx_reg <= emit_idx_reg + BUF_W'(1);
            end
            done_reg <= cmd.out_page || cmd.out_ack || cmd.out_refuse;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.alloc_start)
        begin
            page_buf_reg[0] <= free_head_reg[ADDR_W-1:0];
        end
        else if (cmd.alloc_step)
        begin
            page_buf_reg[walk_cnt_reg[BUF_W-1:0]] <= ram_rdata[ADDR_W-1:0];
        end
        if (cmd.rel_start)
        begin
            rel_head_reg <= chain_head;
            prev_reg     <= chain_head;
        end
        else if (cmd.rel_step)
        begin
            prev_reg <= ram_rdata[ADDR_W-1:0];
        end

        if (cmd.out_page)
        begin
            status_reg    <= ST_DONE;
            page_addr_reg <= page_buf_reg[emit_idx_reg];
            last_reg      <= stat.emit_last;
        end
        else
        begin
            status_reg    <= cmd.out_refuse ? ST_REFUSED : ST_DONE;
            page_addr_reg <= '0;
            last_reg      <= 1'b1;
        end
        free_count_out_reg <= free_count_reg;
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign page_addr  = page_addr_reg;
    assign free_count = free_count_out_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

[design/pfla_ctrl.sv]
// ---------------------------------------------------------------------------
// Page free list allocator - controller
// Sequences the clearing pass, list walks, splices and result requests.
// ---------------------------------------------------------------------------
`default_nettype none

module pfla_ctrl
    import pfla_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       req_type,
    input  wire pfla_stat_t stat,
    output pfla_cmd_t       cmd,
    output logic            busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (req_type == REQ_ALLOC)
                    begin
                        if (stat.free_low || !stat.head_ok)
                        begin
                            state_next = S_REFUSE;
                        end
                        else
                        begin
                            cmd.alloc_start = 1'b1;
                            state_next      = S_A_WALK;
                        end
                    end
                    else if (!stat.chain_ok)
                    begin
                        state_next = S_ACK;
                    end
                    else
                    begin
                        cmd.rel_start = 1'b1;
                        state_next    = S_R_WALK;
                    end
                end
            end
            S_A_WALK:
            begin
                // link of the last taken page becomes the new free head
                if (stat.walk_done)
                begin
                    cmd.alloc_commit = 1'b1;
                    state_next       = S_A_EMIT;
                end
                else if (!stat.link_ok)
                begin
                    state_next = S_REFUSE;
                end
                else
                begin
                    cmd.alloc_step = 1'b1;
                end
            end
            S_A_EMIT:
            begin
                cmd.out_page = 1'b1;
                if (stat.emit_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_R_WALK:
            begin
                if (!stat.link_ok)
                begin
                    cmd.rel_commit = 1'b1;
                    state_next     = S_ACK;
                end
                else if (stat.walk_limit)
                begin
                    state_next = S_ACK;   // no end found: left untouched
                end
                else
                begin
                    cmd.rel_step = 1'b1;
                end
            end
            S_ACK:
            begin
                cmd.out_ack = 1'b1;
                state_next  = S_IDLE;
            end
            S_REFUSE:
            begin
                cmd.out_refuse = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

[design/page_free_list_allocator.sv]
// ---------------------------------------------------------------------------
// Page free list allocator - top level
// Linked free list of physical pages with allocate and release requests.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Results appear on
// the result ports for one cycle each, marked by done, and cannot be held
// off. After reset the link memory is initialised with busy high. The link
// memory is read once per cycle, so an allocate or release walks its list
// one link per read; the page results of an allocate come on consecutive
// cycles. An allocate is refused on the free count, on an empty list, or
// part way down the list when a link read finds no page. A release whose
// chain has no end is dropped after PAGE_COUNT reads. Each result shows in
// the cycle after it is produced.
`default_nettype none

`include "page_free_list_allocator_macros.svh"

module page_free_list_allocator
    import pfla_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              req_type,
    input  wire logic [ADDR_W-1:0] chain_head,
    output logic                   done,
    output logic                   status,
    output logic      [ADDR_W-1:0] page_addr,
    output logic      [CNT_W-1:0]  free_count,
    output logic                   last
);

    pfla_cmd_t  cmd;
    pfla_stat_t stat;

    pfla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    pfla_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .chain_head (chain_head),
        .cmd        (cmd),
        .stat       (stat),
        .done       (done),
        .status     (status),
        .page_addr  (page_addr),
        .free_count (free_count),
        .last       (last)
    );

    `PFLA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request did not set busy")
    `PFLA_ASSERT_NXT(a_pages_burst, done && !last, done, "gap inside an allocate burst")
    `PFLA_ASSERT_IMP(a_refuse_form, done && status, last && (page_addr == '0), "bad refusal")
    `PFLA_ASSERT_IMP(a_count_range, done, free_count <= CNT_W'(PAGE_COUNT), "count overflow")

endmodule

`default_nettype wire

[tb/tb_page_free_list_allocator.sv]
// ---------------------------------------------------------------------------
// Page free list allocator - testbench
// Drives allocate and release requests through the start/busy handshake and
// checks every result against a cycle-free model of the free list, link
// memory and free count. Runs directed cases, biased random traffic with
// well-formed releases, then misuse: partial chains, double releases and
// random heads.
// ---------------------------------------------------------------------------
module tb_page_free_list_allocator;
    import pfla_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    typedef struct {
        status_t           status;
        logic [ADDR_W-1:0] page;
        logic [CNT_W-1:0]  count;
        logic              last;
    } page_result_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              req_type;
    logic [ADDR_W-1:0] chain_head;
    logic              done;
    logic              status;
    logic [ADDR_W-1:0] page_addr;
    logic [CNT_W-1:0]  free_count;
    logic              last;

    // model of the allocator
    logic [LINK_W-1:0] page_link [PAGE_COUNT];
    logic [LINK_W-1:0] pool_head;
    logic [CNT_W-1:0]  pool_count;

    page_result_t      pending_results [$];
    logic [ADDR_W-1:0] granted_chains [$];

    int error_count;
    int cycle_count;
    int idle_max;
    int n_requests;
    int n_pages_granted;
    int n_refused;
    int n_spliced;
    int n_ignored;
    bit last_refused;

    page_free_list_allocator DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .chain_head (chain_head),
        .done       (done),
        .status     (status),
        .page_addr  (page_addr),
        .free_count (free_count),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_result(input status_t st, input logic [ADDR_W-1:0] pg,
                               input logic lst);
        page_result_t r;
        r.status = st;
        r.page   = pg;
        r.count  = pool_count;
        r.last   = lst;
        pending_results.push_back(r);
    endtask

    task automatic reset_pool();
        for (int i = 0; i < PAGE_COUNT; i++)
        begin
            page_link[i] = LINK_W'(i + 1);
        end
        pool_head  = '0;
        pool_count = CNT_W'(PAGE_COUNT);
    endtask

    function automatic bit is_page(input logic [LINK_W-1:0] p);
        return p < PAGE_COUNT;
    endfunction

    // Works out the results of one accepted request and updates the model.
    task automatic predict_request(input req_type_t kind, input logic [ADDR_W-1:0] head);
        logic [LINK_W-1:0] p;
        logic [LINK_W-1:0] prev;
        bit                short_list;
        int                steps;
        p            = pool_head;
        prev         = pool_head;
        short_list   = 1'b0;
        last_refused = 1'b0;
        n_requests++;
        if (kind == REQ_ALLOC)
        begin
            if (pool_count < PAGES_PER_PROC)
            begin
                short_list = 1'b1;
            end
            else
            begin
                // list may end early if it has been corrupted by misuse
                for (int i = 0; i < PAGES_PER_PROC; i++)
                begin
                    if (!is_page(p))
                    begin
                        short_list = 1'b1;
                        break;
                    end
                    p = page_link[p];
                end
            end
            if (short_list)
            begin
                last_refused = 1'b1;
                n_refused++;
                push_result(ST_REFUSED, '0, 1'b1);
            end
            else
            begin
                pool_count = pool_count - CNT_W'(PAGES_PER_PROC);
                p = pool_head;
                granted_chains.push_back(p[ADDR_W-1:0]);
                for (int i = 0; i < PAGES_PER_PROC; i++)
                begin
                    prev = p;
                    p    = page_link[prev];
                    push_result(ST_DONE, prev[ADDR_W-1:0], i == PAGES_PER_PROC - 1);
                end
                page_link[prev] = NULL_LINK;
                pool_head       = p;
                n_pages_granted += PAGES_PER_PROC;
            end
        end
        else
        begin
            p     = LINK_W'(head);
            prev  = p;
            steps = 0;
            while (steps < PAGE_COUNT && is_page(p))
            begin
                prev = p;
                p    = page_link[p];
                steps++;
            end
            if (is_page(p))
            begin
                // no end within PAGE_COUNT steps: left alone
                n_ignored++;
            end
            else
            begin
                page_link[prev] = pool_head;
                pool_head       = LINK_W'(head);
                if (pool_count + PAGES_PER_PROC > PAGE_COUNT)
                begin
                    pool_count = CNT_W'(PAGE_COUNT);
                end
                else
                begin
                    pool_count = pool_count + CNT_W'(PAGES_PER_PROC);
                end
                n_spliced++;
            end
            push_result(ST_DONE, '0, 1'b1);
        end
    endtask

    task automatic send_request(input req_type_t kind, input logic [ADDR_W-1:0] head);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        req_type   <= kind;
        chain_head <= head;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        predict_request(kind, head);
    endtask

    task automatic send_alloc();
        send_request(REQ_ALLOC, ADDR_W'($urandom_range(0, PAGE_COUNT - 1)));
    endtask

    task automatic release_chain(input int idx);
        logic [ADDR_W-1:0] head;
        head = granted_chains[idx];
        granted_chains.delete(idx);
        send_request(REQ_RELEASE, head);
    endtask

    task automatic check_field(input string name, input int exp_val, input int got_val);
        if (exp_val != got_val)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got_val);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        page_result_t r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got page %0d count %0d",
                         $time, page_addr, free_count);
                error_count++;
            end
            else
            begin
                r = pending_results.pop_front();
                check_field("status", r.status, status);
                check_field("page_addr", r.page, page_addr);
                check_field("free_count", r.count, free_count);
                check_field("last", r.last, last);
            end
        end
    end

    // Pages come out in order after reset; released chains go to the front.
    task automatic test_directed_order();
        idle_max = 0;
        send_request(REQ_ALLOC, '0);
        send_request(REQ_ALLOC, '1);
        send_request(REQ_ALLOC, 7'h55);
        send_request(REQ_ALLOC, 7'h2A);
        release_chain(1);
        release_chain(0);
        idle_max = 6;
        send_alloc();
        send_alloc();
        while (granted_chains.size() > 0)
        begin
            release_chain(granted_chains.size() - 1);
        end
    endtask

    // Well-formed traffic in phases that lean towards allocate or release,
    // so the pool drains to empty and refills to full.
    task automatic test_random_traffic(input int n_items);
        int alloc_pct;
        alloc_pct = 50;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 40 == 0)
            begin
                alloc_pct = ((i / 40) % 2 == 0) ? 80 : 20;
                idle_max  = ($urandom_range(0, 3) == 0) ? 0 : 6;
            end
            if (granted_chains.size() == 0 || $urandom_range(1, 100) <= alloc_pct)
            begin
                send_alloc();
            end
            else
            begin
                release_chain($urandom_range(0, granted_chains.size() - 1));
            end
        end
    endtask

    // Partial chain release, double release forming a loop, release of a
    // chain with no end, then random heads.
    task automatic test_misuse(input int n_noise);
        logic [ADDR_W-1:0] whole;
        logic [ADDR_W-1:0] tail_part;
        int                guard;
        idle_max = 6;
        guard    = 0;
        do
        begin
            send_alloc();
            guard++;
        end
        while (!last_refused && guard < 40);
        whole     = granted_chains[0];
        tail_part = page_link[whole][ADDR_W-1:0];
        send_request(REQ_RELEASE, tail_part);
        send_alloc();                              // count says enough, list too short
        send_request(REQ_RELEASE, whole);          // closes the free list into a loop
        send_request(REQ_RELEASE, whole);          // walk never ends
        send_alloc();
        send_alloc();
        for (int i = 0; i < n_noise; i++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                send_alloc();
            end
            else
            begin
                send_request(REQ_RELEASE, ADDR_W'($urandom_range(0, PAGE_COUNT - 1)));
            end
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        req_type        = REQ_ALLOC;
        chain_head      = '0;
        error_count     = 0;
        cycle_count     = 0;
        idle_max        = 0;
        n_requests      = 0;
        n_pages_granted = 0;
        n_refused       = 0;
        n_spliced       = 0;
        n_ignored       = 0;
        last_refused    = 1'b0;
        reset_pool();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_order();
        test_random_traffic(280);
        test_misuse(40);

        start <= 1'b0;
        while (pending_results.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("Covered %0d requests: %0d pages granted, %0d allocates refused",
                 n_requests, n_pages_granted, n_refused);
        $display("Releases: %0d spliced into the free list, %0d with no end left alone",
                 n_spliced, n_ignored);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/pfla_pkg.sv
design/pfla_ram.sv
design/pfla_datapath.sv
design/pfla_ctrl.sv
design/page_free_list_allocator.sv
tb/tb_page_free_list_allocator.sv
